FILE: rtl/ggvc_pkg.sv
// ----------------------------------------------------------------------------
// ggvc_pkg
// Shared constants, types and the CORDIC angle table of the go-to-goal
// velocity controller.
// ----------------------------------------------------------------------------
package ggvc_pkg;

    // Number of CORDIC micro-rotations, one pipeline stage each (8 to 24).
    localparam int CORDIC_STAGES = 16;
    localparam int STG_W         = $clog2(CORDIC_STAGES);

    // Fixed field widths.
    localparam int POS_W     = 16;
    localparam int HEAD_W    = 15;
    localparam int LIN_W     = 17;
    localparam int TURN_W    = 18;
    localparam int DIFF_W    = POS_W + 1;
    localparam int GUARD_W   = 12;
    // Offset scaled by the guard bits plus headroom for the CORDIC gain.
    localparam int XY_W      = DIFF_W + GUARD_W + 3;
    // Angle accumulator in Q30 radians, covers pi plus the full table sum.
    localparam int Z_W       = 35;
    localparam int ATAN_W    = 31;
    localparam int BRG_SH    = 18;
    localparam int ZQ_W      = Z_W + 1 - BRG_SH;

    // Distance scaling by the inverse CORDIC gain.
    localparam int GAIN_W    = 30;
    localparam int PROD_W    = (XY_W - 1) + GAIN_W;
    localparam int DIST_SH   = 42;
    localparam int DISTW_W   = PROD_W + 1 - DIST_SH;
    localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;
    localparam logic [Z_W-1:0]    PI_Q30       = 35'd3373259426;
    localparam int PI_Q12    = 12868;
    localparam int DIST_MAX  = 131071;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd2;

    // One vector in flight through the rotation stages.
    typedef struct packed {
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [Z_W-1:0]    z;
        logic signed [HEAD_W-1:0] heading;
    } vec_t;

    // atan(2^-i) in Q30 radians, rounded.
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 31'd843314857;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043837;
            5'd3:    v = 31'd133525159;
            5'd4:    v = 31'd67021687;
            5'd5:    v = 31'd33543516;
            5'd6:    v = 31'd16775851;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194283;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048576;
            5'd11:   v = 31'd524288;
            5'd12:   v = 31'd262144;
            5'd13:   v = 31'd131072;
            5'd14:   v = 31'd65536;
            5'd15:   v = 31'd32768;
            5'd16:   v = 31'd16384;
            5'd17:   v = 31'd8192;
            5'd18:   v = 31'd4096;
            5'd19:   v = 31'd2048;
            5'd20:   v = 31'd1024;
            5'd21:   v = 31'd512;
            5'd22:   v = 31'd256;
            5'd23:   v = 31'd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/ggvc_prerot.sv
// ----------------------------------------------------------------------------
// ggvc_prerot
// Input stage: forms the offset to the goal, scales it by the guard bits and
// folds the left half plane onto the right with a start angle of +-pi.
// ----------------------------------------------------------------------------
module ggvc_prerot (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [ggvc_pkg::POS_W-1:0]    goal_x,
    input  logic signed [ggvc_pkg::POS_W-1:0]    goal_y,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [ggvc_pkg::POS_W-1:0]    pose_x,
    input  logic signed [ggvc_pkg::POS_W-1:0]    pose_y,
    input  logic signed [ggvc_pkg::HEAD_W-1:0]   pose_heading,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output ggvc_pkg::vec_t                       out_vec
);

    logic signed [ggvc_pkg::DIFF_W-1:0] dx;
    logic signed [ggvc_pkg::DIFF_W-1:0] dy;
    logic signed [ggvc_pkg::XY_W-1:0]   x_scaled;
    logic signed [ggvc_pkg::XY_W-1:0]   y_scaled;
    ggvc_pkg::vec_t                     vec_next;
    ggvc_pkg::vec_t                     vec_reg;
    logic                               valid_reg;

    // Offset from pose to goal, one bit wider than the operands.
    assign dx = {goal_x[ggvc_pkg::POS_W-1], goal_x} - {pose_x[ggvc_pkg::POS_W-1], pose_x};
    assign dy = {goal_y[ggvc_pkg::POS_W-1], goal_y} - {pose_y[ggvc_pkg::POS_W-1], pose_y};

    assign x_scaled = {{(ggvc_pkg::XY_W - ggvc_pkg::DIFF_W - ggvc_pkg::GUARD_W){dx[ggvc_pkg::DIFF_W-1]}},
                       dx, {ggvc_pkg::GUARD_W{1'b0}}};
    assign y_scaled = {{(ggvc_pkg::XY_W - ggvc_pkg::DIFF_W - ggvc_pkg::GUARD_W){dy[ggvc_pkg::DIFF_W-1]}},
                       dy, {ggvc_pkg::GUARD_W{1'b0}}};

    // A vector pointing left is turned by pi so the rotations converge.
    always_comb
    begin
        vec_next.heading = pose_heading;
        if (dx[ggvc_pkg::DIFF_W-1])
        begin
            vec_next.x = -x_scaled;
            vec_next.y = -y_scaled;
            vec_next.z = dy[ggvc_pkg::DIFF_W-1] ? -ggvc_pkg::PI_Q30 : ggvc_pkg::PI_Q30;
        end
        else
        begin
            vec_next.x = x_scaled;
            vec_next.y = y_scaled;
            vec_next.z = '0;
        end
    end

    // Stage register; it also takes an item while the next stage frees up.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

FILE: rtl/ggvc_cordic_stage.sv
// ----------------------------------------------------------------------------
// ggvc_cordic_stage
// One registered CORDIC vectoring micro-rotation that drives y toward zero.
// ----------------------------------------------------------------------------
module ggvc_cordic_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ggvc_pkg::STG_W-1:0]     stage_idx,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ggvc_pkg::vec_t                 in_vec,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ggvc_pkg::vec_t                 out_vec
);

    logic signed [ggvc_pkg::XY_W-1:0] xs;
    logic signed [ggvc_pkg::XY_W-1:0] ys;
    logic [ggvc_pkg::Z_W-1:0]         atan_ext;
    ggvc_pkg::vec_t                   vec_next;
    ggvc_pkg::vec_t                   vec_reg;
    logic                             valid_reg;

    // Arithmetic shifts round toward minus infinity.
    assign xs       = in_vec.x >>> stage_idx;
    assign ys       = in_vec.y >>> stage_idx;
    assign atan_ext = ggvc_pkg::Z_W'(ggvc_pkg::atan_q30(5'(stage_idx)));

    // Rotate clockwise while y is positive, otherwise counterclockwise.
    always_comb
    begin
        vec_next.heading = in_vec.heading;
        if (in_vec.y > 0)
        begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + atan_ext;
        end
        else
        begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - atan_ext;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

FILE: rtl/ggvc_cordic.sv
// ----------------------------------------------------------------------------
// ggvc_cordic
// Chain of CORDIC vectoring stages, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module ggvc_cordic (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ggvc_pkg::vec_t   in_vec,
    output logic             out_valid,
    input  logic             out_ready,
    output ggvc_pkg::vec_t   out_vec
);

    logic           valid_chain [ggvc_pkg::CORDIC_STAGES+1];
    logic           ready_chain [ggvc_pkg::CORDIC_STAGES+1];
    ggvc_pkg::vec_t vec_chain   [ggvc_pkg::CORDIC_STAGES+1];

    assign valid_chain[0] = in_valid;
    assign vec_chain[0]   = in_vec;
    assign in_ready       = ready_chain[0];

    // Stage i shifts by i and uses the i-th table angle.
    for (genvar i = 0; i < ggvc_pkg::CORDIC_STAGES; i++)
    begin : g_stage
        ggvc_cordic_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_idx (ggvc_pkg::STG_W'(i)),
            .in_valid  (valid_chain[i]),
            .in_ready  (ready_chain[i]),
            .in_vec    (vec_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_ready (ready_chain[i+1]),
            .out_vec   (vec_chain[i+1])
        );
    end

    assign ready_chain[ggvc_pkg::CORDIC_STAGES] = out_ready;
    assign out_valid = valid_chain[ggvc_pkg::CORDIC_STAGES];
    assign out_vec   = vec_chain[ggvc_pkg::CORDIC_STAGES];

endmodule

FILE: rtl/ggvc_post.sv
// ----------------------------------------------------------------------------
// ggvc_post
// Output stages: gain correction and bearing rounding, then distance rounding,
// arrival check and turn command into the output register.
// ----------------------------------------------------------------------------
module ggvc_post (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [ggvc_pkg::POS_W-1:0]            arrive_tolerance,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  ggvc_pkg::vec_t                        in_vec,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ggvc_pkg::LIN_W-1:0]            linear_speed,
    output logic signed [ggvc_pkg::TURN_W-1:0]    turn_speed,
    output logic                                  arrived
);

    localparam logic signed [ggvc_pkg::ZQ_W-1:0] BRG_MAX = ggvc_pkg::ZQ_W'(ggvc_pkg::PI_Q12);
    localparam logic signed [ggvc_pkg::ZQ_W-1:0] BRG_MIN = -BRG_MAX;

    // ---- Stage A signals ----
    logic [ggvc_pkg::XY_W-2:0]            x_pos;
    logic [ggvc_pkg::PROD_W-1:0]          prod_next;
    logic [ggvc_pkg::Z_W:0]               z_rnd;
    logic signed [ggvc_pkg::ZQ_W-1:0]     z_q;
    logic signed [ggvc_pkg::HEAD_W-1:0]   bearing_next;
    logic [ggvc_pkg::PROD_W-1:0]          prod_reg;
    logic signed [ggvc_pkg::HEAD_W-1:0]   bearing_reg;
    logic signed [ggvc_pkg::HEAD_W-1:0]   heading_reg;
    logic                                 a_valid_reg;
    logic                                 a_ready;

    // ---- Stage B signals ----
    logic [ggvc_pkg::PROD_W:0]            dist_rnd;
    logic [ggvc_pkg::DISTW_W-1:0]         dist_wide;
    logic [ggvc_pkg::LIN_W-1:0]           dist_sat;
    logic signed [ggvc_pkg::HEAD_W:0]     err;
    logic                                 arrived_next;
    logic [ggvc_pkg::LIN_W-1:0]           lin_reg;
    logic signed [ggvc_pkg::TURN_W-1:0]   turn_reg;
    logic                                 arrived_reg;
    logic                                 b_valid_reg;

    // Negative x is clipped to zero before the gain multiply.
    assign x_pos     = in_vec.x[ggvc_pkg::XY_W-1] ? '0 : in_vec.x[ggvc_pkg::XY_W-2:0];
    assign prod_next = ggvc_pkg::PROD_W'(x_pos) * ggvc_pkg::PROD_W'(ggvc_pkg::INV_GAIN_Q30);

    // Bearing: round Q30 to Q12 by floor of half-up, then clamp to +-pi.
    assign z_rnd = {in_vec.z[ggvc_pkg::Z_W-1], in_vec.z}
                   + (ggvc_pkg::Z_W+1)'(1 << (ggvc_pkg::BRG_SH - 1));
    assign z_q   = z_rnd[ggvc_pkg::Z_W:ggvc_pkg::BRG_SH];

    always_comb
    begin
        if (z_q > BRG_MAX)
        begin
            bearing_next = BRG_MAX[ggvc_pkg::HEAD_W-1:0];
        end
        else if (z_q < BRG_MIN)
        begin
            bearing_next = BRG_MIN[ggvc_pkg::HEAD_W-1:0];
        end
        else
        begin
            bearing_next = z_q[ggvc_pkg::HEAD_W-1:0];
        end
    end

    assign in_ready = !a_valid_reg || a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            prod_reg    <= prod_next;
            bearing_reg <= bearing_next;
            heading_reg <= in_vec.heading;
        end
    end

    // Distance: round the product to Q10 and saturate to the output width.
    assign dist_rnd  = {1'b0, prod_reg} + (ggvc_pkg::PROD_W+1)'(64'd1 << (ggvc_pkg::DIST_SH - 1));
    assign dist_wide = dist_rnd[ggvc_pkg::PROD_W:ggvc_pkg::DIST_SH];
    assign dist_sat  = (dist_wide > ggvc_pkg::DISTW_W'(ggvc_pkg::DIST_MAX))
                       ? ggvc_pkg::LIN_W'(ggvc_pkg::DIST_MAX)
                       : dist_wide[ggvc_pkg::LIN_W-1:0];

    assign arrived_next = (dist_sat <= ggvc_pkg::LIN_W'(arrive_tolerance));
    assign err = {bearing_reg[ggvc_pkg::HEAD_W-1], bearing_reg}
                 - {heading_reg[ggvc_pkg::HEAD_W-1], heading_reg};

    // Output register: holds the result while the receiver stalls.
    assign a_ready = !b_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && a_valid_reg)
        begin
            arrived_reg <= arrived_next;
            if (arrived_next)
            begin
                lin_reg  <= '0;
                turn_reg <= '0;
            end
            else
            begin
                lin_reg  <= dist_sat;
                turn_reg <= {err, 2'b00};
            end
        end
    end

    assign out_valid    = b_valid_reg;
    assign linear_speed = lin_reg;
    assign turn_speed   = turn_reg;
    assign arrived      = arrived_reg;

endmodule

FILE: rtl/go_to_goal_velocity_controller.sv
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller
// Proportional go-to-goal controller: pose in, speed commands out.
// ----------------------------------------------------------------------------
// Each input item on the s_ channel is one measured pose. The block forms
// the offset to the goal, finds distance and bearing with a pipelined CORDIC
// vectoring unit, and returns one item on the m_ channel: the linear speed
// (distance, Q10), the turn speed (4 times bearing minus heading, Q12) and,
// in m_tuser, the arrival flag, which zeroes both speeds when the distance
// is at or below the tolerance.
// Each item passes one input stage, one register per micro-rotation, one
// stage for the gain multiply and one output register. One item is taken
// every cycle unless a stall on m_tready backs up the stages; the depth is
// set by the CORDIC stage count.
// Each stage holds its item while the stage after it is full, so a stall on
// m_tready fills empty stages first and lowers s_tready only once every
// stage holds an item. Nothing is dropped or repeated.
// Reset clears all valid bits and loads goal (5.0, 5.0) and tolerance 10;
// an unknown cfg_index is ignored. The user writes goal and tolerance via
// cfg_we, cfg_index and cfg_data while no item is in flight (not enforced).
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [ggvc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ggvc_pkg::POS_W-1:0]          cfg_data,
    // Pose items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [47:0]                         s_tdata,  // pose_x, pose_y, pose_heading, pad
    // Speed command items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [39:0]                         m_tdata,  // linear_speed, turn_speed, pad
    output logic                                m_tuser   // arrived
);

    logic signed [ggvc_pkg::POS_W-1:0]   goal_x_reg;
    logic signed [ggvc_pkg::POS_W-1:0]   goal_y_reg;
    logic [ggvc_pkg::POS_W-1:0]          tol_reg;

    logic                                pre_valid;
    logic                                pre_ready;
    ggvc_pkg::vec_t                      pre_vec;
    logic                                rot_valid;
    logic                                rot_ready;
    ggvc_pkg::vec_t                      rot_vec;

    logic [ggvc_pkg::LIN_W-1:0]          linear_speed;
    logic signed [ggvc_pkg::TURN_W-1:0]  turn_speed;
    logic                                arrived;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= 16'sd5120;
            goal_y_reg <= 16'sd5120;
            tol_reg    <= 16'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ggvc_pkg::REG_GOAL_X:    goal_x_reg <= cfg_data;
                ggvc_pkg::REG_GOAL_Y:    goal_y_reg <= cfg_data;
                ggvc_pkg::REG_TOLERANCE: tol_reg    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Offset and half-plane fold.
    ggvc_prerot u_prerot (
        .clk          (clk),
        .rst_n        (rst_n),
        .goal_x       (goal_x_reg),
        .goal_y       (goal_y_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .pose_x       (s_tdata[15:0]),
        .pose_y       (s_tdata[31:16]),
        .pose_heading (s_tdata[46:32]),
        .out_valid    (pre_valid),
        .out_ready    (pre_ready),
        .out_vec      (pre_vec)
    );

    // Vectoring rotations.
    ggvc_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pre_valid),
        .in_ready  (pre_ready),
        .in_vec    (pre_vec),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_vec   (rot_vec)
    );

    // Scaling, arrival check and output register.
    ggvc_post u_post (
        .clk              (clk),
        .rst_n            (rst_n),
        .arrive_tolerance (tol_reg),
        .in_valid         (rot_valid),
        .in_ready         (rot_ready),
        .in_vec           (rot_vec),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .linear_speed     (linear_speed),
        .turn_speed       (turn_speed),
        .arrived          (arrived)
    );

    assign m_tdata = {5'b0, turn_speed, linear_speed};
    assign m_tuser = arrived;

    // An arrival result carries zero speeds.
    a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[16:0] == '0) && (m_tdata[34:17] == '0))
        else $error("arrival result with nonzero speed");

    // A moving command always has a distance above zero.
    a_moving_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[16:0] != '0))
        else $error("moving result with zero distance");

    // The input side only backs up when the output is held by the receiver.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

endmodule
